// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the field scan RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define JFS_ASSERT_IMP(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
`define JFS_ASSERT_NXT(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define JFS_ASSERT_IMP(label, ck, rn, ante, cons)
`define JFS_ASSERT_NXT(label, ck, rn, ante, cons)
`endif
`endif

// ===== hdl/jfs_pkg.sv =====
// Package for the JSON top-level field scan unit: widths, character codes,
// scan phase and status encodings, register map. No dependencies.
`timescale 1ns / 1ps

package jfs_pkg;

	localparam int KEY_MAX_BYTES = 16;
	localparam int KEY_LEN_W     = 5;
	localparam int KIDX_W        = $clog2(KEY_MAX_BYTES + 1);
	localparam int KSEL_W        = $clog2(KEY_MAX_BYTES);
	localparam int DEPTH_W       = 8;
	localparam logic [DEPTH_W-1:0] DEPTH_MAX = 8'd255;
	localparam int VALUE_W       = 64;
	localparam int STATUS_W      = 3;
	localparam int CFG_ADDR_W    = 5;
	localparam int CFG_DATA_W    = 64;

	// Character codes
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	typedef enum logic [2:0] {
		PH_SCAN   = 3'd0,
		PH_KEY    = 3'd1,
		PH_COLON  = 3'd2,
		PH_VALUE  = 3'd3,
		PH_DIGITS = 3'd4
	} phase_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_FOUND    = 3'd0,
		ST_ABSENT   = 3'd1,
		ST_NOT_INT  = 3'd2,
		ST_OVERFLOW = 3'd3,
		ST_TRAILING = 3'd4
	} status_t;

	// Register indexes (byte address / 8)
	localparam logic [1:0] REG_KEY_LENGTH = 2'd0;
	localparam logic [1:0] REG_KEY_LOW    = 2'd1;
	localparam logic [1:0] REG_KEY_HIGH   = 2'd2;

endpackage

// ===== hdl/json_top_level_u64_field_scan_unit.sv =====
// JSON top-level field scan unit: takes one document byte per cycle while not
// stalled, finds a configured key at depth one and reports its unsigned 64-bit value.
// Depends on jfs_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// One byte is accepted every cycle while in_stall is low, back to back, with no
// gaps between documents. The byte in the input register updates the scan state
// (depth, string and escape flags, key match position, accumulator) when it is
// taken; the result, if that byte decides one, is loaded into the output register
// at the same edge. The rate is set by the scan state update, whose longest path
// is the multiply-by-ten and digit add with its overflow test. Each document
// yields exactly one result, at the deciding byte or at the byte marked last;
// later bytes up to the last one give nothing. A stalled output holds the input
// side only while a byte waits in the input register. Key registers are written
// over the APB port at byte addresses 0, 8 and 16; the user must write them only
// while the block is idle, as the block itself does not enforce it.
module json_top_level_u64_field_scan_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [jfs_pkg::CFG_ADDR_W-1:0]      paddr,
	input  logic [jfs_pkg::CFG_DATA_W-1:0]      pwdata,
	output logic [jfs_pkg::CFG_DATA_W-1:0]      prdata,
	output logic                                pready,
	// byte input
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [7:0]                          text_byte,
	input  logic                                last_byte,
	// result output
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [jfs_pkg::STATUS_W-1:0]        status,
	output logic [jfs_pkg::VALUE_W-1:0]         field_value
);
	import jfs_pkg::*;

	// configuration registers
	logic [KEY_LEN_W-1:0]         key_length_q;
	logic [63:0]                  key_low_q;
	logic [63:0]                  key_high_q;
	logic                         cfg_write;

	// input stage
	logic                         valid_s1;
	logic [7:0]                   byte_s1;
	logic                         last_s1;
	logic                         fire;

	// scan state
	logic [DEPTH_W-1:0]           depth_q, depth_n;
	logic                         in_str_q, in_str_n;
	logic                         esc_q, esc_n;
	phase_t                       phase_q, phase_n;
	logic [KIDX_W-1:0]            kidx_q, kidx_n;
	logic [VALUE_W-1:0]           acc_q, acc_n;
	logic                         decided_q;

	// output register
	logic                         out_valid_q;
	status_t                      status_q;
	logic [VALUE_W-1:0]           field_value_q;

	// datapath helpers
	logic [KIDX_W-1:0]            key_len_eff;
	logic [8*KEY_MAX_BYTES-1:0]   key_all;
	logic [7:0]                   key_byte;
	logic                         key_hit;
	logic [7:0]                   digit_diff;
	logic [3:0]                   digit;
	logic                         is_digit;
	logic                         is_space;
	logic [VALUE_W+3:0]           acc_sum;
	logic                         acc_ovf;
	logic                         do_scan;
	logic                         emit;
	status_t                      st;

	// configuration write and read
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_length_q <= '0;
			key_low_q    <= '0;
			key_high_q   <= '0;
		end else if (cfg_write) begin
			case (paddr[4:3])
				REG_KEY_LENGTH: key_length_q <= pwdata[KEY_LEN_W-1:0];
				REG_KEY_LOW:    key_low_q    <= pwdata;
				REG_KEY_HIGH:   key_high_q   <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:3])
			REG_KEY_LENGTH: prdata = {{(CFG_DATA_W-KEY_LEN_W){1'b0}}, key_length_q};
			REG_KEY_LOW:    prdata = key_low_q;
			REG_KEY_HIGH:   prdata = key_high_q;
			default:        prdata = '0;
		endcase
	end

	// input register: hold the byte while the output side is stalled
	assign in_stall = valid_s1 && out_valid_q && out_stall;
	assign fire     = valid_s1 && !(out_valid_q && out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= text_byte;
			last_s1 <= last_byte;
		end
	end

	// key compare and digit arithmetic
	assign key_len_eff = (key_length_q > KEY_LEN_W'(KEY_MAX_BYTES)) ?
		KIDX_W'(KEY_MAX_BYTES) : KIDX_W'(key_length_q);
	assign key_all  = {key_high_q, key_low_q};
	assign key_byte = key_all[kidx_q[KSEL_W-1:0]*8 +: 8];
	assign key_hit  = (byte_s1 == key_byte);

	assign digit_diff = byte_s1 - CH_ZERO;
	assign digit      = digit_diff[3:0];
	assign is_digit   = (byte_s1 >= CH_ZERO) && (byte_s1 <= CH_NINE);
	assign is_space   = byte_s1 inside {CH_SPACE, CH_TAB, CH_LF, CH_CR};

	// acc * 10 + digit as (acc << 3) + (acc << 1) + digit; any carry out is overflow
	assign acc_sum = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
		+ {{VALUE_W{1'b0}}, digit};
	assign acc_ovf = |acc_sum[VALUE_W+3:VALUE_W];

	// next scan state
	always_comb begin
		depth_n  = depth_q;
		in_str_n = in_str_q;
		esc_n    = esc_q;
		phase_n  = phase_q;
		kidx_n   = kidx_q;
		acc_n    = acc_q;
		do_scan  = 1'b0;

		if (byte_s1 != CH_NUL) begin
			case (phase_q)
				PH_KEY: begin
					if (kidx_q < key_len_eff) begin
						if (key_hit) begin
							kidx_n = kidx_q + 1'b1;
						end else begin
							phase_n = PH_SCAN;
							do_scan = 1'b1;
						end
					end else if (byte_s1 == CH_QUOTE) begin
						in_str_n = 1'b0;
						phase_n  = PH_COLON;
					end else begin
						phase_n = PH_SCAN;
						do_scan = 1'b1;
					end
				end
				PH_COLON: begin
					if (byte_s1 == CH_COLON) begin
						phase_n = PH_VALUE;
					end else if (!is_space) begin
						phase_n = PH_SCAN;
						do_scan = 1'b1;
					end
				end
				PH_VALUE: begin
					if (is_digit) begin
						acc_n   = {{(VALUE_W-4){1'b0}}, digit};
						phase_n = PH_DIGITS;
					end
				end
				PH_DIGITS: begin
					if (is_digit && !acc_ovf) begin
						acc_n = acc_sum[VALUE_W-1:0];
					end
				end
				default: begin
					phase_n = PH_SCAN;
					do_scan = 1'b1;
				end
			endcase
		end

		// ordinary string, escape and nesting tracking
		if (do_scan) begin
			if (in_str_q) begin
				if (esc_q) begin
					esc_n = 1'b0;
				end else if (byte_s1 == CH_BSLASH) begin
					esc_n = 1'b1;
				end else if (byte_s1 == CH_QUOTE) begin
					in_str_n = 1'b0;
				end
			end else if (byte_s1 == CH_QUOTE) begin
				in_str_n = 1'b1;
				if (depth_q == DEPTH_W'(1)) begin
					phase_n = PH_KEY;
					kidx_n  = '0;
				end
			end else if (byte_s1 inside {CH_LBRACE, CH_LBRACK}) begin
				if (depth_q < DEPTH_MAX) depth_n = depth_q + 1'b1;
			end else if (byte_s1 inside {CH_RBRACE, CH_RBRACK}) begin
				if (depth_q != '0) depth_n = depth_q - 1'b1;
			end
		end
	end

	// result decision for this byte, then end-of-text on the last byte
	always_comb begin
		emit = 1'b0;
		st   = ST_ABSENT;
		if (byte_s1 == CH_NUL) begin
			emit = 1'b1;
			case (phase_q)
				PH_DIGITS: st = ST_TRAILING;
				PH_VALUE:  st = ST_NOT_INT;
				default:   st = ST_ABSENT;
			endcase
		end else if (phase_q == PH_VALUE) begin
			if (!is_space && !is_digit) begin
				emit = 1'b1;
				st   = ST_NOT_INT;
			end
		end else if (phase_q == PH_DIGITS) begin
			emit = 1'b1;
			if (is_digit) begin
				emit = acc_ovf;
				st   = ST_OVERFLOW;
			end else if (is_space || byte_s1 == CH_COMMA || byte_s1 == CH_RBRACE) begin
				st = ST_FOUND;
			end else begin
				st = ST_TRAILING;
			end
		end
		if (!emit && last_s1) begin
			emit = 1'b1;
			case (phase_n)
				PH_DIGITS: st = ST_TRAILING;
				PH_VALUE:  st = ST_NOT_INT;
				default:   st = ST_ABSENT;
			endcase
		end
		if (decided_q) emit = 1'b0;
	end

	// scan state update: clear after the last byte, freeze once decided
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q   <= '0;
			in_str_q  <= 1'b0;
			esc_q     <= 1'b0;
			phase_q   <= PH_SCAN;
			kidx_q    <= '0;
			acc_q     <= '0;
			decided_q <= 1'b0;
		end else if (fire) begin
			if (last_s1) begin
				depth_q   <= '0;
				in_str_q  <= 1'b0;
				esc_q     <= 1'b0;
				phase_q   <= PH_SCAN;
				kidx_q    <= '0;
				acc_q     <= '0;
				decided_q <= 1'b0;
			end else if (!decided_q) begin
				depth_q   <= depth_n;
				in_str_q  <= in_str_n;
				esc_q     <= esc_n;
				phase_q   <= phase_n;
				kidx_q    <= kidx_n;
				acc_q     <= acc_n;
				decided_q <= emit;
			end
		end
	end

	// output register: load on a decided byte, drop after the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= emit;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			status_q      <= st;
			field_value_q <= (st == ST_FOUND) ? acc_q : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign field_value = field_value_q;

	// checks
	`JFS_ASSERT_NXT(a_last_clears, clk, arst_n, fire && last_s1, !decided_q && phase_q == PH_SCAN && depth_q == '0 && !in_str_q)
	`JFS_ASSERT_NXT(a_last_reports, clk, arst_n, fire && last_s1 && !decided_q, out_valid_q)
	`JFS_ASSERT_NXT(a_no_second_result, clk, arst_n, fire && decided_q, !out_valid_q)
	`JFS_ASSERT_IMP(a_value_only_found, clk, arst_n, out_valid_q && status_q != ST_FOUND, field_value_q == '0)
	`JFS_ASSERT_IMP(a_kidx_bound, clk, arst_n, 1'b1, kidx_q <= KIDX_W'(KEY_MAX_BYTES))

endmodule
